/* hdl/cps_pkg.sv */
// shared types and codes of the point cluster proximity store
package cps_pkg;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_NEAR  = 3'd1;
    localparam logic [2:0] REQ_LAST  = 3'd2;
    localparam logic [2:0] REQ_EXIST = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] point_x;
        logic [31:0] point_y;
    } req_item_t;

    typedef struct packed {
        logic        match;
        logic        full_error;
        logic [8:0]  stored_count;
        logic [31:0] box_x_min;
        logic [31:0] box_x_max;
        logic [31:0] box_y_min;
        logic [31:0] box_y_max;
    } rsp_item_t;

    typedef struct packed {
        logic exec_op;
        logic start_scan;
        logic scan_step;
        logic load_scan;
    } cps_cmd_t;

    typedef struct packed {
        logic req_is_scan;
        logic scan_done;
    } cps_stat_t;

endpackage

/* hdl/point_cluster_proximity_store_top.sv */
// top level of the point cluster proximity store: config registers, controller, datapath
//
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_item   (req_type, point_x, point_y)
// rsp       out        rsp_valid / rsp_ready  rsp_item   (match, full_error, count, box)
// apb       in         psel / penable         paddr, pwdata, prdata
//
// add, clear and unused types: result registered at the accept edge, one item per cycle while the slot is free
// near and exist tests: one stored point compared per cycle through the point ram read
//   port, newest first; a scan ends at a hit, an x stop (near only) or after the oldest point
// last-point test: only the newest point is compared; any test on an empty store: no match
// reset: asynchronous, empties the store; point ram contents are not cleared
// a result not taken holds req_ready low; scans wait in a done state for the slot
module point_cluster_proximity_store_top #(
    parameter int POINT_DEPTH = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  cps_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output cps_pkg::rsp_item_t rsp_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cps_pkg::*;

    logic [15:0] x_limit_reg;
    logic [15:0] x_limit_next;
    logic [15:0] y_limit_reg;
    logic [15:0] y_limit_next;
    logic        cfg_write;
    logic        reg_sel;
    cps_cmd_t    cmd;
    cps_stat_t   stat;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        x_limit_next = x_limit_reg;
        y_limit_next = y_limit_reg;
        if (cfg_write && reg_sel == REG_X_LIMIT)
        begin
            x_limit_next = pwdata[15:0];
        end
        if (cfg_write && reg_sel == REG_Y_LIMIT)
        begin
            y_limit_next = pwdata[15:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_X_LIMIT: prdata = {16'h0000, x_limit_reg};
            REG_Y_LIMIT: prdata = {16'h0000, y_limit_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= '0;
            y_limit_reg <= '0;
        end
        else
        begin
            x_limit_reg <= x_limit_next;
            y_limit_reg <= y_limit_next;
        end
    end

    cps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cps_dp #(
        .POINT_DEPTH (POINT_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_item (req_item),
        .x_limit  (x_limit_reg),
        .y_limit  (y_limit_reg),
        .rsp_item (rsp_item)
    );

endmodule

/* hdl/cps_ram.sv */
// generic single write port, single read port ram with registered read
module cps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/cps_ctrl.sv */
// controller state machine: handshakes and sequencing of non-scan ops and scans
module cps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  cps_pkg::cps_stat_t stat,
    output cps_pkg::cps_cmd_t  cmd
);
    import cps_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = slot_free;
                if (req_valid && slot_free)
                begin
                    if (stat.req_is_scan)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        cmd.exec_op    = 1'b1;
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_scan  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec_op, cmd.start_scan, cmd.scan_step, cmd.load_scan}))
        else $error("more than one datapath command at once");

    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_scan |=> state_reg == S_SCAN)
        else $error("scan start did not enter scan state");

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_scan |-> (!rsp_valid_reg || rsp_ready))
        else $error("scan result loaded over an untaken item");

endmodule

/* hdl/cps_dp.sv */
// datapath: point memory, count, bounding box, scan unit and result register
module cps_dp #(
    parameter int POINT_DEPTH = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cps_pkg::cps_cmd_t  cmd,
    output cps_pkg::cps_stat_t stat,
    input  cps_pkg::req_item_t req_item,
    input  logic [15:0]        x_limit,
    input  logic [15:0]        y_limit,
    output cps_pkg::rsp_item_t rsp_item
);
    import cps_pkg::*;

    localparam int AW    = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
    localparam int CNT_W = $clog2(POINT_DEPTH + 1);
    localparam int LW    = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
    localparam logic [CNT_W-1:0]       DEPTH_CNT  = CNT_W'(POINT_DEPTH);
    localparam logic [COORD_WIDTH-1:0] COORD_ONES = '1;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [COORD_WIDTH-1:0] min_x_reg, min_x_next;
    logic [COORD_WIDTH-1:0] max_x_reg, max_x_next;
    logic [COORD_WIDTH-1:0] min_y_reg, min_y_next;
    logic [COORD_WIDTH-1:0] max_y_reg, max_y_next;
    logic [COORD_WIDTH-1:0] qx_reg, qx_next;
    logic [COORD_WIDTH-1:0] qy_reg, qy_next;
    logic                   exist_reg, exist_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   pend_reg, pend_next;
    logic                   match_reg, match_next;
    rsp_item_t              rsp_reg, rsp_next;

    logic [COORD_WIDTH-1:0]   in_x, in_y;
    logic                     full;
    logic                     add_err;
    logic                     wr_en;
    logic                     rd_en;
    logic [2*COORD_WIDTH-1:0] rd_data;
    logic [COORD_WIDTH-1:0]   sx, sy;
    logic [COORD_WIDTH-1:0]   dx, dy;
    logic [LW-1:0]            dx_w, dy_w, xlim_w, ylim_sum;
    logic                     near_hit, exist_hit, far_stop, hit;

    assign in_x = req_item.point_x[COORD_WIDTH-1:0];
    assign in_y = req_item.point_y[COORD_WIDTH-1:0];
    assign full = count_reg >= DEPTH_CNT;

    assign stat.req_is_scan = req_item.req_type inside {REQ_NEAR, REQ_LAST, REQ_EXIST};

    assign wr_en = cmd.exec_op && (req_item.req_type == REQ_ADD) && !full;
    assign rd_en = cmd.scan_step && (left_reg != '0);

    cps_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (POINT_DEPTH)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({in_x, in_y}),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // neighbor and stop tests against the point read last cycle
    assign sx        = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
    assign sy        = rd_data[COORD_WIDTH-1:0];
    assign dx        = (qx_reg >= sx) ? (qx_reg - sx) : (sx - qx_reg);
    assign dy        = (qy_reg >= sy) ? (qy_reg - sy) : (sy - qy_reg);
    assign dx_w      = LW'(dx);
    assign dy_w      = LW'(dy);
    assign xlim_w    = LW'(x_limit);
    assign ylim_sum  = LW'(y_limit) + dx_w;
    assign near_hit  = (dx_w <= xlim_w) && (dy_w <= ylim_sum);
    assign exist_hit = (qx_reg == sx) && (qy_reg == sy);
    assign far_stop  = !exist_reg && (qx_reg > sx) && (dx_w > xlim_w);
    assign hit       = exist_reg ? exist_hit : near_hit;

    assign stat.scan_done = pend_reg ? (hit || far_stop) : (left_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        add_err    = 1'b0;
        if (cmd.exec_op)
        begin
            case (req_item.req_type)
                REQ_ADD:
                begin
                    if (full)
                    begin
                        add_err = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (in_x < min_x_reg) min_x_next = in_x;
                        if (in_x > max_x_reg) max_x_next = in_x;
                        if (in_y < min_y_reg) min_y_next = in_y;
                        if (in_y > max_y_reg) max_y_next = in_y;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                    min_x_next = COORD_ONES;
                    max_x_next = '0;
                    min_y_next = COORD_ONES;
                    max_y_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        exist_next = exist_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        pend_next  = 1'b0;
        match_next = match_reg;
        if (cmd.start_scan)
        begin
            qx_next    = in_x;
            qy_next    = in_y;
            exist_next = req_item.req_type == REQ_EXIST;
            addr_next  = AW'(count_reg - 1'b1);
            pend_next  = 1'b0;
            if (req_item.req_type == REQ_LAST)
            begin
                left_next = (count_reg != '0) ? CNT_W'(1) : '0;
            end
            else
            begin
                left_next = count_reg;
            end
        end
        else if (cmd.scan_step)
        begin
            pend_next = rd_en;
            if (rd_en)
            begin
                addr_next = addr_reg - 1'b1;
                left_next = left_reg - 1'b1;
            end
            if (stat.scan_done)
            begin
                match_next = pend_reg && hit;
            end
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.exec_op)
        begin
            rsp_next.match        = 1'b0;
            rsp_next.full_error   = add_err;
            rsp_next.stored_count = 9'(count_next);
            rsp_next.box_x_min    = 32'(min_x_next);
            rsp_next.box_x_max    = 32'(max_x_next);
            rsp_next.box_y_min    = 32'(min_y_next);
            rsp_next.box_y_max    = 32'(max_y_next);
        end
        else if (cmd.load_scan)
        begin
            rsp_next.match        = match_reg;
            rsp_next.full_error   = 1'b0;
            rsp_next.stored_count = 9'(count_reg);
            rsp_next.box_x_min    = 32'(min_x_reg);
            rsp_next.box_x_max    = 32'(max_x_reg);
            rsp_next.box_y_min    = 32'(min_y_reg);
            rsp_next.box_y_max    = 32'(max_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_x_reg <= COORD_ONES;
            max_x_reg <= '0;
            min_y_reg <= COORD_ONES;
            max_y_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        exist_reg <= exist_next;
        addr_reg  <= addr_next;
        match_reg <= match_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_item = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("point count beyond store depth");

    a_pend_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(rd_en))
        else $error("scan compare without a preceding read");

    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> (min_x_reg == COORD_ONES && max_x_reg == '0 &&
                             min_y_reg == COORD_ONES && max_y_reg == '0))
        else $error("empty store with a non-empty box");

endmodule
